// ===== src/kufe_pkg.sv =====
// Package for the union-find engine: result status codes, sequencer states
// and the write-enable group between the sequencer and the store.
// No dependencies.
package kufe_pkg;

    typedef enum logic [1:0] {
        ST_JOINED    = 2'd0,
        ST_CONNECTED = 2'd1,
        ST_IGNORED   = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_WALK   = 6'b000100,
        S_HALVE  = 6'b001000,
        S_SIZE_A = 6'b010000,
        S_LINK   = 6'b100000
    } t_state;

    typedef struct packed {
        logic p_we;
        logic s_we;
    } t_mem_ctl;

endpackage

// ===== src/kufe_store.sv =====
// Disjoint-set store: parent link memory and set size memory, each with one
// write port and one registered read port.
// Depends on kufe_pkg.
module kufe_store import kufe_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int SW    = 11
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [AW-1:0] i_p_raddr,
    input  logic [AW-1:0] i_p_waddr,
    input  logic [AW-1:0] i_p_wdata,
    output logic [AW-1:0] o_p_rdata,
    input  logic [AW-1:0] i_s_raddr,
    input  logic [AW-1:0] i_s_waddr,
    input  logic [SW-1:0] i_s_wdata,
    output logic [SW-1:0] o_s_rdata
);

    logic [AW-1:0] r_parent [DEPTH];
    logic [SW-1:0] r_size   [DEPTH];
    logic [AW-1:0] r_p_rdata;
    logic [SW-1:0] r_s_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.p_we) begin
            r_parent[i_p_waddr] <= i_p_wdata;
        end
        r_p_rdata <= r_parent[i_p_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s_we) begin
            r_size[i_s_waddr] <= i_s_wdata;
        end
        r_s_rdata <= r_size[i_s_raddr];
    end

    assign o_p_rdata = r_p_rdata;
    assign o_s_rdata = r_s_rdata;

endmodule

// ===== src/kufe_seq.sv =====
// Sequencer of the union-find engine: clearing sweep, root walks with path
// halving, union by size, edge count and result registers.
// Depends on kufe_pkg; drives kufe_store.
module kufe_seq import kufe_pkg::*; #(
    parameter int MAX_VERTICES = 1024,
    parameter int AW           = 10,
    parameter int SW           = 11,
    parameter int CW           = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  logic [9:0]    i_first_vertex,
    input  logic [9:0]    i_second_vertex,
    input  logic [CW-1:0] i_eff_count,
    output logic          o_done,
    output logic [1:0]    o_status,
    output logic [9:0]    o_accepted_count,
    output logic          o_complete,
    output t_mem_ctl      o_ctl,
    output logic [AW-1:0] o_p_raddr,
    output logic [AW-1:0] o_p_waddr,
    output logic [AW-1:0] o_p_wdata,
    input  logic [AW-1:0] i_p_rdata,
    output logic [AW-1:0] o_s_raddr,
    output logic [AW-1:0] o_s_waddr,
    output logic [SW-1:0] o_s_wdata,
    input  logic [SW-1:0] i_s_rdata
);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [9:0]    r_acc, n_acc;
    logic          r_tdone, n_tdone;
    logic          r_done, n_done;
    t_status       r_status, n_status;
    logic [9:0]    r_acc_out, n_acc_out;
    logic          r_cmp_out, n_cmp_out;
    logic [AW-1:0] r_v, n_v;
    logic [AW-1:0] r_b, n_b;
    logic [AW-1:0] r_ra, n_ra;
    logic [SW-1:0] r_sa, n_sa;
    logic          r_phase, n_phase;

    logic          w_complete;
    logic          w_range;
    logic [9:0]    w_acc_inc;
    logic          w_join_cmp;
    logic [AW-1:0] w_big;
    logic [AW-1:0] w_small;

    assign w_complete = r_tdone || ((CW'(r_acc) + CW'(1)) >= i_eff_count);
    assign w_range    = (CW'(i_first_vertex) >= i_eff_count)
                     || (CW'(i_second_vertex) >= i_eff_count);
    assign w_acc_inc  = r_acc + 10'd1;
    assign w_join_cmp = r_tdone || ((CW'(w_acc_inc) + CW'(1)) >= i_eff_count);
    assign w_big      = (r_sa < i_s_rdata) ? r_v : r_ra;
    assign w_small    = (r_sa < i_s_rdata) ? r_ra : r_v;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        n_tdone   = r_tdone;
        n_done    = 1'b0;
        n_status  = r_status;
        n_acc_out = r_acc_out;
        n_cmp_out = r_cmp_out;
        n_v       = r_v;
        n_b       = r_b;
        n_ra      = r_ra;
        n_sa      = r_sa;
        n_phase   = r_phase;
        o_ctl     = '0;
        o_p_raddr = r_v;
        o_p_waddr = r_v;
        o_p_wdata = i_p_rdata;
        o_s_raddr = r_ra;
        o_s_waddr = r_ra;
        o_s_wdata = SW'(1);
        case (r_state)
            S_INIT: begin
                o_ctl.p_we = 1'b1;
                o_ctl.s_we = 1'b1;
                o_p_waddr  = r_cnt;
                o_p_wdata  = r_cnt;
                o_s_waddr  = r_cnt;
                o_s_wdata  = SW'(1);
                n_cnt      = r_cnt + AW'(1);
                if (r_cnt == AW'(MAX_VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (w_complete) begin
                        n_tdone   = 1'b1;
                        n_done    = 1'b1;
                        n_status  = ST_IGNORED;
                        n_acc_out = r_acc;
                        n_cmp_out = 1'b1;
                    end else if (w_range) begin
                        n_done    = 1'b1;
                        n_status  = ST_RANGE;
                        n_acc_out = r_acc;
                        n_cmp_out = 1'b0;
                    end else begin
                        n_v       = AW'(i_first_vertex);
                        n_b       = AW'(i_second_vertex);
                        o_p_raddr = AW'(i_first_vertex);
                        n_phase   = 1'b0;
                        n_state   = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (i_p_rdata == r_v) begin
                    if (!r_phase) begin
                        n_ra      = r_v;
                        n_v       = r_b;
                        o_p_raddr = r_b;
                        n_phase   = 1'b1;
                    end else if (r_ra == r_v) begin
                        n_done    = 1'b1;
                        n_status  = ST_CONNECTED;
                        n_acc_out = r_acc;
                        n_cmp_out = 1'b0;
                        n_state   = S_IDLE;
                    end else begin
                        o_s_raddr = r_ra;
                        n_state   = S_SIZE_A;
                    end
                end else begin
                    o_p_raddr = i_p_rdata;
                    n_state   = S_HALVE;
                end
            end
            S_HALVE: begin
                o_ctl.p_we = 1'b1;
                o_p_waddr  = r_v;
                o_p_wdata  = i_p_rdata;
                n_v        = i_p_rdata;
                o_p_raddr  = i_p_rdata;
                n_state    = S_WALK;
            end
            S_SIZE_A: begin
                n_sa      = i_s_rdata;
                o_s_raddr = r_v;
                n_state   = S_LINK;
            end
            S_LINK: begin
                o_ctl.p_we = 1'b1;
                o_ctl.s_we = 1'b1;
                o_p_waddr  = w_small;
                o_p_wdata  = w_big;
                o_s_waddr  = w_big;
                o_s_wdata  = r_sa + i_s_rdata;
                n_acc      = w_acc_inc;
                n_tdone    = w_join_cmp;
                n_done     = 1'b1;
                n_status   = ST_JOINED;
                n_acc_out  = w_acc_inc;
                n_cmp_out  = w_join_cmp;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= '0;
            r_acc   <= '0;
            r_tdone <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_acc   <= n_acc;
            r_tdone <= n_tdone;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_acc_out <= n_acc_out;
        r_cmp_out <= n_cmp_out;
        r_v       <= n_v;
        r_b       <= n_b;
        r_ra      <= n_ra;
        r_sa      <= n_sa;
        r_phase   <= n_phase;
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_accepted_count = r_acc_out;
    assign o_complete       = r_cmp_out;

endmodule

// ===== src/kruskal_union_find_engine_unit.sv =====
// Ignored or refused edges give their result in the cycle after start; other edges
// walk both roots with path halving, then stop if connected or read sizes and join.
// Throughput: one edge at a time; busy drops in the cycle of the result strobe.
// Reset: synchronous; a clearing sweep of all MAX_VERTICES entries follows it with
// busy high. The result strobe lasts one cycle and cannot be held off.
module kruskal_union_find_engine_unit import kufe_pkg::*; #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  i_first_vertex,
    input  logic [9:0]  i_second_vertex,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [9:0]  o_accepted_count,
    output logic        o_complete
);

    localparam int AW = $clog2(MAX_VERTICES);
    localparam int SW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (SW > 11) ? SW : 11;

    logic [10:0]   r_num_vertices;
    logic [CW-1:0] w_eff_count;
    t_mem_ctl      w_ctl;
    logic [AW-1:0] w_p_raddr, w_p_waddr, w_p_wdata, w_p_rdata;
    logic [AW-1:0] w_s_raddr, w_s_waddr;
    logic [SW-1:0] w_s_wdata, w_s_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= 11'd1024;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_num_vertices <= pwdata[10:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {21'd0, r_num_vertices};

    assign w_eff_count = (CW'(r_num_vertices) > CW'(MAX_VERTICES)) ?
                         CW'(MAX_VERTICES) : CW'(r_num_vertices);

    kufe_seq #(
        .MAX_VERTICES (MAX_VERTICES),
        .AW           (AW),
        .SW           (SW),
        .CW           (CW)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .o_busy           (busy),
        .i_first_vertex   (i_first_vertex),
        .i_second_vertex  (i_second_vertex),
        .i_eff_count      (w_eff_count),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_accepted_count (o_accepted_count),
        .o_complete       (o_complete),
        .o_ctl            (w_ctl),
        .o_p_raddr        (w_p_raddr),
        .o_p_waddr        (w_p_waddr),
        .o_p_wdata        (w_p_wdata),
        .i_p_rdata        (w_p_rdata),
        .o_s_raddr        (w_s_raddr),
        .o_s_waddr        (w_s_waddr),
        .o_s_wdata        (w_s_wdata),
        .i_s_rdata        (w_s_rdata)
    );

    kufe_store #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW),
        .SW    (SW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_p_raddr (w_p_raddr),
        .i_p_waddr (w_p_waddr),
        .i_p_wdata (w_p_wdata),
        .o_p_rdata (w_p_rdata),
        .i_s_raddr (w_s_raddr),
        .i_s_waddr (w_s_waddr),
        .i_s_wdata (w_s_wdata),
        .o_s_rdata (w_s_rdata)
    );

endmodule

// ===== src/kufe_chk.sv =====
// Port-level checker for the union-find engine and its bind to the top level.
// Depends on kufe_pkg.
module kufe_chk import kufe_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic       o_complete
);

    a_sweep_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("Engine not busy after reset.");

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(start && !busy) || $past(busy)))
        else $error("Result without a request.");

    a_ignored_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_IGNORED) |-> o_complete)
        else $error("Ignored request while tree not complete.");

    a_range_not_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_RANGE) |-> !o_complete)
        else $error("Range refusal while tree complete.");

endmodule

bind kruskal_union_find_engine_unit kufe_chk u_kufe_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_done     (o_done),
    .o_status   (o_status),
    .o_complete (o_complete)
);
